[rtl/nbra_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbra_pkg
// Shared types and constants of the narrow band render analyzer.
// ----------------------------------------------------------------------------
package nbra_pkg;

    // request codes
    localparam logic [2:0] FUNC_BIN    = 3'd0;
    localparam logic [2:0] FUNC_SAMPLE = 3'd1;
    localparam logic [2:0] FUNC_FRAME  = 3'd2;
    localparam logic [2:0] FUNC_ABSENT = 3'd3;
    localparam logic [2:0] FUNC_QUERY  = 3'd4;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic [3:0]  COUNT_MAX    = 4'd15;
    localparam logic [3:0]  POOR_LIMIT   = 4'd10;
    localparam logic [3:0]  MASK_LIMIT   = 4'd5;
    localparam logic [16:0] AMP_FLOOR    = 17'd100;
    localparam logic [6:0]  STRONG_RATIO = 7'd100;
    localparam logic [15:0] FREEZE_RESET = 16'd1000;
    localparam logic [7:0]  NO_BAND      = 8'hFF;

    // strong peak window: 5 to 14 bins on either side
    localparam logic signed [4:0] WIN_FAR_LO  = -5'sd14;
    localparam logic signed [4:0] WIN_FAR_HI  = 5'sd14;
    localparam logic signed [4:0] WIN_NEAR_LO = -5'sd5;
    localparam logic signed [4:0] WIN_NEAR_HI = 5'sd5;

    typedef struct packed {
        logic [2:0]         func;
        logic [31:0]        psd_value;
        logic signed [15:0] sample_value;
        logic [6:0]         bin_index;
    } req_t;

    typedef struct packed {
        logic              result_kind;
        logic signed [7:0] peak_band;
        logic              poor_drive;
        logic              mask_zero;
    } result_t;

    // counter bank control
    typedef struct packed {
        logic       shift;
        logic       clear;
        logic [3:0] value;
    } cnt_ctl_t;

endpackage

[rtl/nbra_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbra_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module nbra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/nbra_cnt_bank.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbra_cnt_bank
// Persistence counters as a rotating shift line, with the mask lookup.
// ----------------------------------------------------------------------------
module nbra_cnt_bank
    import nbra_pkg::*;
#(
    parameter int NUM_BINS = 65
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cnt_ctl_t   ctl,
    output logic [3:0] head,
    input  logic [6:0] query_bin,
    output logic       masked
);

    localparam int NC    = NUM_BINS - 2;
    localparam int H     = NUM_BINS - 1;
    localparam int IDX_W = $clog2(NUM_BINS);
    localparam int QW    = ((IDX_W > 7) ? IDX_W : 7) + 1;

    logic [3:0]          cnt_reg [NC];
    logic [NC-1:0]       over_mask;
    logic [NUM_BINS-1:0] mask_vec;
    logic [QW-1:0]       qidx;

    // one step moves every counter down by one; the new value enters at the tail
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NC; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (ctl.clear)
        begin
            for (int i = 0; i < NC; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (ctl.shift)
        begin
            for (int i = 0; i < NC - 1; i++)
            begin
                cnt_reg[i] <= cnt_reg[i+1];
            end
            cnt_reg[NC-1] <= ctl.value;
        end
    end

    assign head = cnt_reg[0];

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            over_mask[c] = cnt_reg[c] > MASK_LIMIT;
        end
    end

    // edge counters cover two bins, inner counter c covers bins c-1..c+3
    always_comb
    begin
        int c;
        for (int b = 0; b < NUM_BINS; b++)
        begin
            mask_vec[b] = 1'b0;
            if (b <= 1)
            begin
                mask_vec[b] = mask_vec[b] | over_mask[0];
            end
            if (b >= H - 1)
            begin
                mask_vec[b] = mask_vec[b] | over_mask[NC-1];
            end
            for (int d = -3; d <= 1; d++)
            begin
                c = b + d;
                if (c >= 1 && c <= NC - 2)
                begin
                    mask_vec[b] = mask_vec[b] | over_mask[c];
                end
            end
        end
    end

    assign qidx   = QW'(query_bin);
    assign masked = (qidx < QW'(NUM_BINS)) ? mask_vec[qidx[IDX_W-1:0]] : 1'b0;

endmodule

[rtl/narrow_band_render_analyzer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// narrow_band_render_analyzer
// Render spectrum narrow band detector: persistence counters, strong peak
// latch with freeze timer, and mask queries.
// ----------------------------------------------------------------------------
// Bin and sample requests give no result; busy stays low.
// A mask query returns its result on the cycle after the request, busy low.
// An absent frame end is busy for one cycle; the result follows it.
// A frame end is busy for one pass over the bins through the single RAM read
// port, then the window reads, a multiply and a compare.
// rst_n clears control, counters and timer and loads the freeze duration dur_reg with 1000.
module narrow_band_render_analyzer
    import nbra_pkg::*;
#(
    parameter int NUM_BINS = 65
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    output logic        done,
    output result_t     result,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data
);

    localparam int H     = NUM_BINS - 1;
    localparam int IDX_W = $clog2(NUM_BINS);
    localparam int CNT_W = $clog2(NUM_BINS + 1);
    localparam int AW    = IDX_W + 2;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_WIN    = 3'd2;
    localparam logic [2:0] S_WDRAIN = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_CMP    = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [16:0]       maxabs_reg, maxabs_next;
    logic              amp_ok_reg, amp_ok_next;
    logic              valid_reg, valid_next;
    logic [IDX_W-1:0]  band_reg, band_next;
    logic [15:0]       freeze_reg, freeze_next;
    logic [15:0]       dur_reg, dur_next;
    logic              poor_reg, poor_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic signed [4:0] off_reg, off_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [31:0]       w1_reg, w1_next;
    logic [31:0]       w2_reg, w2_next;
    logic [31:0]       best_reg, best_next;
    logic [IDX_W-1:0]  peak_reg, peak_next;
    logic [31:0]       win_reg, win_next;
    logic [38:0]       prod_reg, prod_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;

    logic              accept;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_raddr;
    logic [31:0]       ram_rdata;
    cnt_ctl_t          cnt_ctl;
    logic [3:0]        cnt_head;
    logic              q_masked;
    logic [16:0]       mag;
    logic              tick_valid;
    logic [15:0]       tick_count;
    logic signed [AW-1:0] win_addr;
    logic              win_ok;
    logic [31:0]       nb;
    logic [33:0]       nb3;
    logic              narrow;
    logic [3:0]        cnt_new;
    logic [IDX_W+7:0]  band_wide;
    logic [7:0]        band_out;

    assign accept = start && !busy;
    assign busy   = state_reg != S_IDLE;
    assign ram_we = accept && req.func == FUNC_BIN && pos_reg < CNT_W'(NUM_BINS);

    nbra_ram #(
        .WIDTH (32),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg[IDX_W-1:0]),
        .wdata (req.psd_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    nbra_cnt_bank #(
        .NUM_BINS (NUM_BINS)
    ) u_cnt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cnt_ctl),
        .head      (cnt_head),
        .query_bin (req.bin_index),
        .masked    (q_masked)
    );

    // sample magnitude; full-scale negative gives 32768
    assign mag = req.sample_value[15] ? (17'h10000 - {1'b0, req.sample_value})
                                      : {1'b0, req.sample_value};

    // freeze timer advance for one frame
    always_comb
    begin
        tick_valid = valid_reg;
        tick_count = freeze_reg;
        if (valid_reg)
        begin
            if ({1'b0, freeze_reg} + 17'd1 > {1'b0, dur_reg})
            begin
                tick_valid = 1'b0;
                tick_count = '0;
            end
            else
            begin
                tick_count = freeze_reg + 16'd1;
            end
        end
    end

    assign win_addr = $signed({2'b00, peak_reg}) + AW'(off_reg);
    assign win_ok   = (win_addr >= 0) && (win_addr <= H)
                      && (off_reg <= WIN_NEAR_LO || off_reg >= WIN_NEAR_HI);
    assign ram_raddr = (state_reg == S_SCAN) ? iss_reg[IDX_W-1:0]
                                             : win_addr[IDX_W-1:0];

    // narrow peak test on the middle of the three-bin window
    assign nb      = (w1_reg > ram_rdata) ? w1_reg : ram_rdata;
    assign nb3     = {2'b00, nb} + {1'b0, nb, 1'b0};
    assign narrow  = {2'b00, w2_reg} > nb3;
    assign cnt_new = narrow ? ((cnt_head == COUNT_MAX) ? COUNT_MAX : cnt_head + 4'd1)
                            : 4'd0;

    assign band_wide = {8'd0, band_reg};
    assign band_out  = valid_reg ? band_wide[7:0] : NO_BAND;

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        maxabs_next = maxabs_reg;
        amp_ok_next = amp_ok_reg;
        valid_next  = valid_reg;
        band_next   = band_reg;
        freeze_next = freeze_reg;
        dur_next    = dur_reg;
        poor_next   = poor_reg;
        iss_next    = iss_reg;
        off_next    = off_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = iss_reg[IDX_W-1:0];
        w1_next     = w1_reg;
        w2_next     = w2_reg;
        best_next   = best_reg;
        peak_next   = peak_reg;
        win_next    = win_reg;
        prod_next   = prod_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        cnt_ctl     = '0;

        if (cfg_we)
        begin
            dur_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.func)
                        FUNC_BIN:
                        begin
                            if (ram_we)
                            begin
                                pos_next = pos_reg + CNT_W'(1);
                            end
                        end
                        FUNC_SAMPLE:
                        begin
                            if (mag > maxabs_reg)
                            begin
                                maxabs_next = mag;
                            end
                        end
                        FUNC_FRAME:
                        begin
                            valid_next  = tick_valid;
                            freeze_next = tick_count;
                            amp_ok_next = maxabs_reg > AMP_FLOOR;
                            maxabs_next = '0;
                            pos_next    = '0;
                            poor_next   = 1'b0;
                            iss_next    = '0;
                            state_next  = S_SCAN;
                        end
                        FUNC_ABSENT:
                        begin
                            valid_next  = tick_valid;
                            freeze_next = tick_count;
                            maxabs_next = '0;
                            pos_next    = '0;
                            poor_next   = 1'b0;
                            cnt_ctl.clear = 1'b1;
                            state_next  = S_EMIT;
                        end
                        FUNC_QUERY:
                        begin
                            done_next = 1'b1;
                            result_next.result_kind = KIND_QUERY;
                            result_next.peak_band   = band_out;
                            result_next.poor_drive  = poor_reg;
                            result_next.mask_zero   = q_masked;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (iss_reg <= CNT_W'(H))
                begin
                    rd_vld_next = 1'b1;
                    iss_next    = iss_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (rd_idx_reg == '0 || ram_rdata > best_reg)
                    begin
                        best_next = ram_rdata;
                        peak_next = rd_idx_reg;
                    end
                    w1_next = w2_reg;
                    w2_next = ram_rdata;
                    if (rd_idx_reg >= IDX_W'(2))
                    begin
                        cnt_ctl.shift = 1'b1;
                        cnt_ctl.value = cnt_new;
                        if (cnt_new > POOR_LIMIT)
                        begin
                            poor_next = 1'b1;
                        end
                    end
                    if (rd_idx_reg == IDX_W'(H))
                    begin
                        off_next   = WIN_FAR_LO;
                        win_next   = '0;
                        state_next = S_WIN;
                    end
                end
            end
            S_WIN, S_WDRAIN:
            begin
                if (rd_vld_reg && ram_rdata > win_reg)
                begin
                    win_next = ram_rdata;
                end
                if (state_reg == S_WIN)
                begin
                    rd_vld_next = win_ok;
                    off_next    = off_reg + 5'sd1;
                    if (off_reg == WIN_FAR_HI)
                    begin
                        state_next = S_WDRAIN;
                    end
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = {7'd0, win_reg} * {32'd0, STRONG_RATIO};
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (peak_reg != '0 && amp_ok_reg && {7'd0, best_reg} > prod_reg)
                begin
                    valid_next  = 1'b1;
                    band_next   = peak_reg;
                    freeze_next = '0;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                done_next = 1'b1;
                result_next.result_kind = KIND_STATUS;
                result_next.peak_band   = band_out;
                result_next.poor_drive  = poor_reg;
                result_next.mask_zero   = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pos_reg    <= '0;
            maxabs_reg <= '0;
            amp_ok_reg <= 1'b0;
            valid_reg  <= 1'b0;
            band_reg   <= '0;
            freeze_reg <= '0;
            dur_reg    <= FREEZE_RESET;
            poor_reg   <= 1'b0;
            iss_reg    <= '0;
            off_reg    <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            maxabs_reg <= maxabs_next;
            amp_ok_reg <= amp_ok_next;
            valid_reg  <= valid_next;
            band_reg   <= band_next;
            freeze_reg <= freeze_next;
            dur_reg    <= dur_next;
            poor_reg   <= poor_next;
            iss_reg    <= iss_next;
            off_reg    <= off_next;
            rd_vld_reg <= rd_vld_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        w1_reg     <= w1_next;
        w2_reg     <= w2_next;
        best_reg   <= best_next;
        peak_reg   <= peak_next;
        win_reg    <= win_next;
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/nbra_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbra_chk
// Port-level checks of the narrow band render analyzer, bound to the top.
// ----------------------------------------------------------------------------
module nbra_chk
    import nbra_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input req_t        req,
    input logic        done,
    input result_t     result,
    input logic        cfg_we,
    input logic [15:0] cfg_data
);

    // a query answers on the very next cycle
    a_query_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.func == FUNC_QUERY |=> done && result.result_kind == KIND_QUERY)
        else $error("mask query request not answered on the next cycle");

    // a frame end, present or absent, always raises busy in the cycle after the request
    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.func == FUNC_FRAME || req.func == FUNC_ABSENT) |=> busy)
        else $error("frame end request did not raise busy");

    // bins and samples produce no result
    a_bin_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.func == FUNC_BIN || req.func == FUNC_SAMPLE) |=> !done && !busy)
        else $error("bin or sample request produced a result or busy");

    // a frame status never carries a mask answer
    a_status_mask: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.result_kind == KIND_STATUS |-> !result.mask_zero)
        else $error("frame status result with mask bit set");

    // busy drops only through a status result
    a_busy_exit: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done && result.result_kind == KIND_STATUS)
        else $error("busy fell without a frame status result");

endmodule

bind narrow_band_render_analyzer nbra_chk u_nbra_chk (.*);
